@@ hdl/sasc_pkg.sv @@
// shared constants and types for the section average speed checker
`timescale 1ns / 1ps
package sasc_pkg;

  localparam int VEHICLE_ENTRIES_DEF = 256;
  localparam int GATE_COUNT_DEF      = 64;

  localparam int GATE_W  = 6;
  localparam int POS_W   = 20;
  localparam int PLATE_W = 64;
  localparam int TIME_W  = 40;
  localparam int CFG_W   = 16;
  localparam int SPEED_W = 24;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 48;

  localparam int FACTOR_W = 19;
  localparam logic [FACTOR_W-1:0] CENTI_KMH_PER_M_PER_MS = 19'd360000;
  localparam int NUM_W = POS_W + FACTOR_W;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  localparam logic [CFG_W-1:0] LIMIT_RESET    = 16'd13000;
  localparam logic [CFG_W-1:0] MIN_INTV_RESET = 16'd100;

  localparam logic REG_SPEED_LIMIT = 1'b0;
  localparam logic REG_MIN_INTV    = 1'b1;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } div_stat_t;

endpackage

@@ hdl/sasc_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module sasc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sasc_pkg::NUM_W-1:0]    num,
  input  logic [sasc_pkg::TIME_W-1:0]   den,
  output logic [sasc_pkg::NUM_W-1:0]    quot,
  output sasc_pkg::div_stat_t           stat
);

  logic [sasc_pkg::NUM_W-1:0]     num_sh_r;
  logic [sasc_pkg::NUM_W-1:0]     quot_r;
  logic [sasc_pkg::TIME_W-1:0]    rem_r;
  logic [sasc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [sasc_pkg::TIME_W:0]      trial;
  logic                           fits;

  assign trial = {rem_r, num_sh_r[sasc_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= sasc_pkg::DIV_CNT_W'(sasc_pkg::NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == sasc_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh_r <= num;
      rem_r    <= '0;
      quot_r   <= '0;
    end else if (busy_r) begin
      num_sh_r <= {num_sh_r[sasc_pkg::NUM_W-2:0], 1'b0};
      quot_r   <= {quot_r[sasc_pkg::NUM_W-2:0], fits};
      if (fits) begin
        rem_r <= sasc_pkg::TIME_W'(trial - {1'b0, den});
      end else begin
        rem_r <= trial[sasc_pkg::TIME_W-1:0];
      end
    end
  end

  assign quot        = quot_r;
  assign stat.done   = done_r;
  assign stat.rem_nz = |rem_r;

endmodule

@@ hdl/sasc_gate_mem.sv @@
// per gate transit counters with clearing pass after reset
`timescale 1ns / 1ps
module sasc_gate_mem #(
  parameter int GATE_COUNT = sasc_pkg::GATE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [$clog2(GATE_COUNT)-1:0]  rd_addr,
  output logic [sasc_pkg::CNT_W-1:0]     rd_data,
  input  logic                           wr_en,
  input  logic [$clog2(GATE_COUNT)-1:0]  wr_addr,
  input  logic [sasc_pkg::CNT_W-1:0]     wr_data,
  output logic                           clr_busy
);

  localparam int GW = $clog2(GATE_COUNT);

  logic [sasc_pkg::CNT_W-1:0] mem [GATE_COUNT];
  logic [sasc_pkg::CNT_W-1:0] rd_data_r;
  logic [GW-1:0]              clr_idx_r;
  logic                       clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == GW'(GATE_COUNT - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

@@ hdl/section_average_speed_checker.sv @@
// top level: vehicle table scan, speed measurement and running totals
//
//  channel | ports                      | direction
//  in      | in_valid, in_stall, in_*   | request in, stall out
//  out     | out_valid, out_stall, out_*| request out, stall in
//  cfg     | cfg_we, cfg_index, cfg_data| write only
//
// one request at a time: the table is scanned (one table read a cycle), a known plate then
// passes the hit step, and the multiply step and the serial divider when a speed is measured;
// the next request can be taken as soon as the result is registered
// after reset the gate counters are cleared, with in_stall high
// the result register lets the next request in while a result is stalled
`timescale 1ns / 1ps
module section_average_speed_checker #(
  parameter int VEHICLE_ENTRIES = sasc_pkg::VEHICLE_ENTRIES_DEF,
  parameter int GATE_COUNT      = sasc_pkg::GATE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sasc_pkg::GATE_W-1:0]   in_gate_id,
  input  logic [sasc_pkg::POS_W-1:0]    in_gate_pos_m,
  input  logic [sasc_pkg::PLATE_W-1:0]  in_plate_key,
  input  logic [sasc_pkg::TIME_W-1:0]   in_time_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_first_seen,
  output logic                          out_measured,
  output logic                          out_fined,
  output logic [sasc_pkg::SPEED_W-1:0]  out_speed_centi_kmh,
  output logic [sasc_pkg::CNT_W-1:0]    out_fine_total,
  output logic [sasc_pkg::CNT_W-1:0]    out_measure_total,
  output logic [sasc_pkg::SUM_W-1:0]    out_speed_total,
  output logic [sasc_pkg::CNT_W-1:0]    out_gate_total,
  output logic                          out_table_full,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sasc_pkg::CFG_W-1:0]    cfg_data
);

  localparam int AW = $clog2(VEHICLE_ENTRIES);
  localparam int CW = $clog2(VEHICLE_ENTRIES + 1);
  localparam int GW = $clog2(GATE_COUNT);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_HIT   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_r;

  logic [sasc_pkg::CFG_W-1:0] limit_r;
  logic [sasc_pkg::CFG_W-1:0] min_intv_r;

  logic [sasc_pkg::GATE_W-1:0]  gate_r;
  logic [sasc_pkg::POS_W-1:0]   pos_r;
  logic [sasc_pkg::PLATE_W-1:0] plate_r;
  logic [sasc_pkg::TIME_W-1:0]  time_r;

  logic [sasc_pkg::PLATE_W-1:0] plate_mem [VEHICLE_ENTRIES];
  logic [sasc_pkg::POS_W-1:0]   pos_mem   [VEHICLE_ENTRIES];
  logic [sasc_pkg::TIME_W-1:0]  time_mem  [VEHICLE_ENTRIES];
  logic [sasc_pkg::PLATE_W-1:0] rd_plate_r;
  logic [sasc_pkg::POS_W-1:0]   rd_pos_r;
  logic [sasc_pkg::TIME_W-1:0]  rd_time_r;

  logic [CW-1:0] fill_r;
  logic [CW-1:0] scan_idx_r;
  logic [AW-1:0] cmp_idx_r;
  logic          cmp_vld_r;
  logic [AW-1:0] hit_idx_r;
  logic          hit_r;
  logic [sasc_pkg::POS_W-1:0]  prev_pos_r;
  logic [sasc_pkg::TIME_W-1:0] prev_time_r;

  logic [sasc_pkg::TIME_W-1:0] gap_r;
  logic [sasc_pkg::POS_W-1:0]  dist_r;
  logic                        meas_r;
  logic [sasc_pkg::NUM_W-1:0]  num_r;
  logic                        div_go_r;
  logic [sasc_pkg::NUM_W-1:0]  quot;
  sasc_pkg::div_stat_t         div_stat;
  logic [sasc_pkg::NUM_W-1:0]  quot_r;
  logic                        rem_nz_r;

  logic [sasc_pkg::CNT_W-1:0]  fine_cnt_r;
  logic [sasc_pkg::CNT_W-1:0]  meas_cnt_r;
  logic [sasc_pkg::SUM_W-1:0]  speed_sum_r;

  logic                        out_valid_r;
  logic                        out_first_seen_r;
  logic                        out_measured_r;
  logic                        out_fined_r;
  logic [sasc_pkg::SPEED_W-1:0] out_speed_r;
  logic [sasc_pkg::CNT_W-1:0]  out_fine_total_r;
  logic [sasc_pkg::CNT_W-1:0]  out_meas_total_r;
  logic [sasc_pkg::SUM_W-1:0]  out_speed_total_r;
  logic [sasc_pkg::CNT_W-1:0]  out_gate_total_r;
  logic                        out_full_r;

  logic [sasc_pkg::CNT_W-1:0]  gate_rd_data;
  logic                        gate_clr_busy;
  logic                        gate_ok;
  logic [GW-1:0]               gate_addr;

  logic                        in_acc;
  logic                        match;
  logic                        fin_go;
  logic [sasc_pkg::TIME_W:0]   gap_full;
  logic                        fined;
  logic [sasc_pkg::SPEED_W-1:0] speed_sat;
  logic                        tbl_wr;
  logic [AW-1:0]               tbl_wr_addr;
  logic                        full;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = state_r != S_IDLE;
  assign match     = cmp_vld_r && (rd_plate_r == plate_r);
  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign gap_full  = {1'b0, time_r} - {1'b0, prev_time_r};
  assign gate_ok   = 32'(gate_r) < GATE_COUNT;
  assign gate_addr = GW'(gate_r);
  assign full      = !hit_r && (fill_r == CW'(VEHICLE_ENTRIES));
  assign fined     = meas_r && ((quot_r > sasc_pkg::NUM_W'(limit_r)) ||
                     ((quot_r == sasc_pkg::NUM_W'(limit_r)) && rem_nz_r));
  assign speed_sat = (|quot_r[sasc_pkg::NUM_W-1:sasc_pkg::SPEED_W]) ? sasc_pkg::SPEED_MAX
                     : quot_r[sasc_pkg::SPEED_W-1:0];
  assign tbl_wr      = fin_go && (hit_r || !full);
  assign tbl_wr_addr = hit_r ? hit_idx_r : fill_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= sasc_pkg::LIMIT_RESET;
      min_intv_r <= sasc_pkg::MIN_INTV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sasc_pkg::REG_SPEED_LIMIT: limit_r    <= cfg_data;
        sasc_pkg::REG_MIN_INTV:    min_intv_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      fill_r      <= '0;
      cmp_vld_r   <= 1'b0;
      div_go_r    <= 1'b0;
      fine_cnt_r  <= '0;
      meas_cnt_r  <= '0;
      speed_sum_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      div_go_r <= state_r == S_MUL;
      if (out_valid_r && !out_stall && !fin_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          if (!gate_clr_busy) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_r   <= S_SCAN;
            cmp_vld_r <= 1'b0;
          end
        end
        S_SCAN: begin
          if (match) begin
            state_r <= S_HIT;
          end else if (scan_idx_r == fill_r) begin
            state_r <= S_FIN;
          end
          cmp_vld_r <= !match && (scan_idx_r != fill_r);
        end
        S_HIT: begin
          state_r <= (meas_r || (!gap_full[sasc_pkg::TIME_W] &&
                     (gap_full[sasc_pkg::TIME_W-1:0] > sasc_pkg::TIME_W'(min_intv_r))))
                     ? S_MUL : S_FIN;
        end
        S_MUL: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            if (!hit_r && !full) begin
              fill_r <= fill_r + 1'b1;
            end
            if (meas_r) begin
              meas_cnt_r  <= meas_cnt_r + 1'b1;
              speed_sum_r <= speed_sum_r + sasc_pkg::SUM_W'(speed_sat);
              if (fined) begin
                fine_cnt_r <= fine_cnt_r + 1'b1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      gate_r     <= in_gate_id;
      pos_r      <= in_gate_pos_m;
      plate_r    <= in_plate_key;
      time_r     <= in_time_ms;
      scan_idx_r <= '0;
      hit_r      <= 1'b0;
      meas_r     <= 1'b0;
    end
    if (state_r == S_SCAN) begin
      if (match) begin
        hit_r       <= 1'b1;
        hit_idx_r   <= cmp_idx_r;
        prev_pos_r  <= rd_pos_r;
        prev_time_r <= rd_time_r;
      end else if (scan_idx_r != fill_r) begin
        cmp_idx_r  <= scan_idx_r[AW-1:0];
        scan_idx_r <= scan_idx_r + 1'b1;
      end
    end
    if (state_r == S_HIT) begin
      gap_r  <= gap_full[sasc_pkg::TIME_W-1:0];
      dist_r <= (pos_r >= prev_pos_r) ? pos_r - prev_pos_r : prev_pos_r - pos_r;
      meas_r <= !gap_full[sasc_pkg::TIME_W] &&
                (gap_full[sasc_pkg::TIME_W-1:0] > sasc_pkg::TIME_W'(min_intv_r));
    end
    if (state_r == S_MUL) begin
      num_r <= sasc_pkg::NUM_W'(dist_r) * sasc_pkg::NUM_W'(sasc_pkg::CENTI_KMH_PER_M_PER_MS);
    end
    if (div_stat.done) begin
      quot_r   <= quot;
      rem_nz_r <= div_stat.rem_nz;
    end
    if (fin_go) begin
      out_first_seen_r  <= !hit_r;
      out_measured_r    <= meas_r;
      out_fined_r       <= fined;
      out_speed_r       <= meas_r ? speed_sat : '0;
      out_fine_total_r  <= (meas_r && fined) ? fine_cnt_r + 1'b1 : fine_cnt_r;
      out_meas_total_r  <= meas_r ? meas_cnt_r + 1'b1 : meas_cnt_r;
      out_speed_total_r <= meas_r ? speed_sum_r + sasc_pkg::SUM_W'(speed_sat) : speed_sum_r;
      out_gate_total_r  <= gate_ok ? gate_rd_data + 1'b1 : '0;
      out_full_r        <= full;
    end
  end

  // vehicle table
  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      if (!hit_r) begin
        plate_mem[tbl_wr_addr] <= plate_r;
      end
      pos_mem[tbl_wr_addr]  <= pos_r;
      time_mem[tbl_wr_addr] <= time_r;
    end
    rd_plate_r <= plate_mem[scan_idx_r[AW-1:0]];
    rd_pos_r   <= pos_mem[scan_idx_r[AW-1:0]];
    rd_time_r  <= time_mem[scan_idx_r[AW-1:0]];
  end

  sasc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go_r),
    .num   (num_r),
    .den   (gap_r),
    .quot  (quot),
    .stat  (div_stat)
  );

  sasc_gate_mem #(
    .GATE_COUNT (GATE_COUNT)
  ) u_gate_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (gate_addr),
    .rd_data  (gate_rd_data),
    .wr_en    (fin_go && gate_ok),
    .wr_addr  (gate_addr),
    .wr_data  (gate_rd_data + 1'b1),
    .clr_busy (gate_clr_busy)
  );

  assign out_valid           = out_valid_r;
  assign out_first_seen      = out_first_seen_r;
  assign out_measured        = out_measured_r;
  assign out_fined           = out_fined_r;
  assign out_speed_centi_kmh = out_speed_r;
  assign out_fine_total      = out_fine_total_r;
  assign out_measure_total   = out_meas_total_r;
  assign out_speed_total     = out_speed_total_r;
  assign out_gate_total      = out_gate_total_r;
  assign out_table_full      = out_full_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(VEHICLE_ENTRIES))
    else $error("table fill count beyond depth");

  a_fine_meas: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fined_r |-> out_measured_r && !out_first_seen_r)
    else $error("fine without measurement");

  a_full_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> out_first_seen_r && !out_measured_r)
    else $error("table full on a known plate");

  a_speed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_measured_r |-> out_speed_r == '0)
    else $error("speed without measurement");

endmodule

@@ tb/section_average_speed_checker_tb.sv @@
// self-checking testbench for the section average speed checker, predictor and checker inside
`timescale 1ns / 1ps
module section_average_speed_checker_tb;

  localparam int ENTRIES        = sasc_pkg::VEHICLE_ENTRIES_DEF;
  localparam int GATES          = sasc_pkg::GATE_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  localparam int GATE_W  = sasc_pkg::GATE_W;
  localparam int POS_W   = sasc_pkg::POS_W;
  localparam int PLATE_W = sasc_pkg::PLATE_W;
  localparam int TIME_W  = sasc_pkg::TIME_W;
  localparam int CFG_W   = sasc_pkg::CFG_W;
  localparam int SPEED_W = sasc_pkg::SPEED_W;
  localparam int CNT_W   = sasc_pkg::CNT_W;
  localparam int SUM_W   = sasc_pkg::SUM_W;

  localparam logic [SPEED_W-1:0] SPEED_MAX      = sasc_pkg::SPEED_MAX;
  localparam logic [CFG_W-1:0]   LIMIT_RESET    = sasc_pkg::LIMIT_RESET;
  localparam logic [CFG_W-1:0]   MIN_INTV_RESET = sasc_pkg::MIN_INTV_RESET;
  localparam logic               REG_SPEED_LIMIT = sasc_pkg::REG_SPEED_LIMIT;
  localparam logic               REG_MIN_INTV    = sasc_pkg::REG_MIN_INTV;
  localparam logic [sasc_pkg::FACTOR_W-1:0] CENTI_KMH_PER_M_PER_MS =
    sasc_pkg::CENTI_KMH_PER_M_PER_MS;

  typedef struct packed {
    logic               first_seen;
    logic               measured;
    logic               fined;
    logic [SPEED_W-1:0] speed;
    logic [CNT_W-1:0]   fine_total;
    logic [CNT_W-1:0]   measure_total;
    logic [SUM_W-1:0]   speed_total;
    logic [CNT_W-1:0]   gate_total;
    logic               table_full;
  } transit_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [GATE_W-1:0]  in_gate_id = '0;
  logic [POS_W-1:0]   in_gate_pos_m = '0;
  logic [PLATE_W-1:0] in_plate_key = '0;
  logic [TIME_W-1:0]  in_time_ms = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_first_seen;
  logic               out_measured;
  logic               out_fined;
  logic [SPEED_W-1:0] out_speed_centi_kmh;
  logic [CNT_W-1:0]   out_fine_total;
  logic [CNT_W-1:0]   out_measure_total;
  logic [SUM_W-1:0]   out_speed_total;
  logic [CNT_W-1:0]   out_gate_total;
  logic               out_table_full;
  logic               cfg_we = 1'b0;
  logic               cfg_index = REG_SPEED_LIMIT;
  logic [CFG_W-1:0]   cfg_data = '0;

  section_average_speed_checker u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted block state
  logic [PLATE_W-1:0] veh_plate [ENTRIES];
  logic               veh_valid [ENTRIES];
  logic [POS_W-1:0]   veh_pos   [ENTRIES];
  logic [TIME_W-1:0]  veh_time  [ENTRIES];
  logic [CNT_W-1:0]   gate_cnt  [GATES];
  logic [CNT_W-1:0]   fine_cnt = '0;
  logic [CNT_W-1:0]   measure_cnt = '0;
  logic [SUM_W-1:0]   speed_acc = '0;
  logic [CFG_W-1:0]   limit_cfg = LIMIT_RESET;
  logic [CFG_W-1:0]   intv_cfg = MIN_INTV_RESET;
  int                 stored_cnt = 0;

  transit_result_t    pending_results [$];
  logic [PLATE_W-1:0] plate_pool [$];
  logic [TIME_W-1:0]  clock_ms;
  int  mismatches = 0;
  int  sent_cnt = 0;
  int  recv_cnt = 0;
  int  fined_seen = 0;
  int  full_seen = 0;
  bit  idle_on = 1'b1;
  int  hold_left = 0;
  int  burst_left = 0;
  int  quiet_cycles = 0;

  function automatic transit_result_t predict_transit(logic [GATE_W-1:0] gate,
      logic [POS_W-1:0] pos, logic [PLATE_W-1:0] plate, logic [TIME_W-1:0] now);
    transit_result_t r;
    int hit;
    int free_slot;
    logic [63:0] gap;
    logic [63:0] span;
    logic [63:0] num;
    logic [63:0] quot;
    r = '0;
    hit = -1;
    free_slot = -1;
    gate_cnt[gate] = gate_cnt[gate] + 1;
    r.gate_total = gate_cnt[gate];
    for (int i = 0; i < ENTRIES; i++) begin
      if (veh_valid[i]) begin
        if (hit < 0 && veh_plate[i] == plate) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit >= 0) begin
      if (now >= veh_time[hit]) begin
        gap = 64'(now) - 64'(veh_time[hit]);
        if (gap > 64'(intv_cfg)) begin
          span = (pos >= veh_pos[hit]) ? 64'(pos - veh_pos[hit]) : 64'(veh_pos[hit] - pos);
          num = span * 64'(CENTI_KMH_PER_M_PER_MS);
          quot = num / gap;
          r.speed = (quot > 64'(SPEED_MAX)) ? SPEED_MAX : quot[SPEED_W-1:0];
          r.measured = 1'b1;
          speed_acc = speed_acc + r.speed;
          measure_cnt = measure_cnt + 1;
          if (num > 64'(limit_cfg) * gap) begin
            r.fined = 1'b1;
            fine_cnt = fine_cnt + 1;
          end
        end
      end
      veh_pos[hit] = pos;
      veh_time[hit] = now;
    end else begin
      r.first_seen = 1'b1;
      if (free_slot >= 0) begin
        veh_valid[free_slot] = 1'b1;
        veh_plate[free_slot] = plate;
        veh_pos[free_slot] = pos;
        veh_time[free_slot] = now;
        stored_cnt++;
      end else begin
        r.table_full = 1'b1;
      end
    end
    r.fine_total = fine_cnt;
    r.measure_total = measure_cnt;
    r.speed_total = speed_acc;
    return r;
  endfunction

  task automatic send_transit(logic [GATE_W-1:0] gate, logic [POS_W-1:0] pos,
      logic [PLATE_W-1:0] plate, logic [TIME_W-1:0] now);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_gate_id <= gate;
    in_gate_pos_m <= pos;
    in_plate_key <= plate;
    in_time_ms <= now;
    do @(posedge clk); while (in_stall);
    pending_results.insert(pending_results.size(), predict_transit(gate, pos, plate, now));
    sent_cnt++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // block must be idle: call only after drain_results
  task automatic write_config(logic [CFG_W-1:0] limit, logic [CFG_W-1:0] intv);
    cfg_we <= 1'b1;
    cfg_index <= REG_SPEED_LIMIT;
    cfg_data <= limit;
    @(posedge clk);
    limit_cfg = limit;
    cfg_index <= REG_MIN_INTV;
    cfg_data <= intv;
    @(posedge clk);
    intv_cfg = intv;
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_transit();
    logic [GATE_W-1:0]  gate;
    logic [POS_W-1:0]   pos;
    logic [PLATE_W-1:0] plate;
    logic [TIME_W-1:0]  now;
    gate = GATE_W'($urandom_range(0, GATES - 1));
    pos = POS_W'(gate * 1000 + $urandom_range(0, 999));
    plate = plate_pool[$urandom_range(0, plate_pool.size() - 1)];
    if ($urandom_range(0, 99) < 85) begin
      clock_ms = clock_ms + $urandom_range(0, 2000000);
      now = clock_ms;
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          plate = {$urandom, $urandom};
          pos = POS_W'($urandom);
          now = clock_ms;
        end
        1: now = clock_ms - $urandom_range(0, 5000);
        default: begin
          clock_ms = clock_ms + $urandom_range(0, 200);
          now = clock_ms;
        end
      endcase
    end
    send_transit(gate, pos, plate, now);
  endtask

  task automatic test_directed();
    logic [PLATE_W-1:0] pa;
    logic [PLATE_W-1:0] pb;
    logic [PLATE_W-1:0] pc;
    pa = '0;
    pb = '1;
    pc = 64'h4142_4331_3233_3435;
    send_transit(0, 0, pa, 0);
    send_transit(63, '1, pa, 1000);
    send_transit(5, 0, pa, 1050);
    send_transit(5, 0, pa, 1150);
    send_transit(6, 0, pa, 1251);
    // exactly at the limit, then just above it
    send_transit(7, 13, pa, 1611);
    send_transit(8, 26, pa, 1970);
    // time going backwards
    send_transit(9, 26, pa, 500);
    send_transit(9, 100, pa, '1);
    send_transit(1, 5, pb, '1);
    send_transit(2, '1, pc, 40'h55_5555_5555);
    send_transit(3, 0, pc, 40'hAA_AAAA_AAAA);
    drain_results();
  endtask

  task automatic test_config_extremes();
    logic [PLATE_W-1:0] pd;
    pd = 64'h5a5a_0000_ffff_1234;
    write_config('0, '0);
    send_transit(10, 0, pd, 1000);
    send_transit(11, 1, pd, 1001);
    send_transit(11, 1, pd, 1001);
    drain_results();
    write_config('1, '1);
    send_transit(12, 100000, pd, 66537);
    send_transit(13, 0, pd, 132072);
    send_transit(14, 0, pd, 200000);
    drain_results();
    write_config(LIMIT_RESET, MIN_INTV_RESET);
  endtask

  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      send_random_transit();
      if (i % 150 == 149) begin
        drain_results();
        write_config(CFG_W'($urandom_range(5000, 30000)), CFG_W'($urandom_range(0, 2000)));
      end
    end
    drain_results();
  endtask

  task automatic test_long_hold();
    hold_left = 400;
    for (int i = 0; i < 12; i++) send_random_transit();
    drain_results();
  endtask

  task automatic test_sender_pause();
    for (int i = 0; i < 8; i++) send_random_transit();
    drain_results();
    repeat (50) @(posedge clk);
  endtask

  task automatic test_table_full();
    logic [PLATE_W-1:0] plate;
    while (stored_cnt < ENTRIES) begin
      plate = {$urandom, $urandom};
      plate_pool.insert(plate_pool.size(), plate);
      clock_ms = clock_ms + $urandom_range(0, 1000);
      send_transit(GATE_W'($urandom), POS_W'($urandom), plate, clock_ms);
    end
    for (int i = 0; i < 6; i++)
      send_transit(GATE_W'($urandom), POS_W'($urandom), {$urandom, $urandom}, clock_ms);
    drain_results();
  endtask

  function automatic void check_field(string name, logic [63:0] expd, logic [63:0] actual);
    if (expd !== actual) begin
      $error("%s: expected %0h, got %0h", name, expd, actual);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    transit_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      recv_cnt++;
      if (pending_results.size() == 0) begin
        $error("result with no pending request");
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        fined_seen += e.fined;
        full_seen += e.table_full;
        check_field("first_seen", e.first_seen, out_first_seen);
        check_field("measured", e.measured, out_measured);
        check_field("fined", e.fined, out_fined);
        check_field("speed_centi_kmh", e.speed, out_speed_centi_kmh);
        check_field("fine_total", e.fine_total, out_fine_total);
        check_field("measure_total", e.measure_total, out_measure_total);
        check_field("speed_total", e.speed_total, out_speed_total);
        check_field("gate_total", e.gate_total, out_gate_total);
        check_field("table_full", e.table_full, out_table_full);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left--;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      burst_left = $urandom_range(1, 14) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) veh_valid[i] = 1'b0;
    for (int i = 0; i < GATES; i++) gate_cnt[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    for (int i = 0; i < 40; i++) plate_pool.insert(plate_pool.size(), {$urandom, $urandom});
    clock_ms = {8'($urandom_range(0, 254)), 32'($urandom)};
    test_random_traffic(600);
    test_long_hold();
    test_sender_pause();
    test_table_full();
    test_random_traffic(450);
    idle_on = 1'b0;
    test_random_traffic(150);
    repeat (100) @(posedge clk);
    $display("covered %0d transits, %0d results, %0d fines, %0d table-full rejects",
             sent_cnt, recv_cnt, fined_seen, full_seen);
    $display("directed edge cases, config extremes, long output stall and full vehicle table");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/sasc_pkg.sv
hdl/sasc_div.sv
hdl/sasc_gate_mem.sv
hdl/section_average_speed_checker.sv
tb/section_average_speed_checker_tb.sv
